@@ src/eer_pkg.sv @@
// Package: shared constants, types and functions for the ECEF/ENU rotation unit
`timescale 1ns / 1ps
package eer_pkg;

   localparam int CordicStepsDefault = 24;
   localparam int AngW = 34;
   localparam int CsW = 34;
   localparam int VecW = 40;

   localparam logic signed [AngW-1:0] HalfPi = 34'sd1686629713;
   localparam logic signed [AngW-1:0] Pi = 34'sd3373259426;
   localparam logic signed [CsW-1:0] Gain = 34'sd652032874;
   localparam logic signed [VecW-1:0] VecMax = {1'b0, {(VecW-1){1'b1}}};
   localparam logic signed [VecW-1:0] VecMin = {1'b1, {(VecW-1){1'b0}}};

   typedef struct packed {
      logic signed [AngW-1:0] z;
      logic signed [CsW-1:0] x;
      logic signed [CsW-1:0] y;
      logic flip;
   } cordic_lane_type;

   typedef struct packed {
      logic func;
      logic signed [VecW-1:0] vx;
      logic signed [VecW-1:0] vy;
      logic signed [VecW-1:0] vz;
   } vec_item_type;

   function automatic logic signed [AngW-1:0] atan_q30(input logic [4:0] i);
      case (i)
         5'd0: atan_q30 = 34'sh03243F6A8;
         5'd1: atan_q30 = 34'sh01DAC6705;
         5'd2: atan_q30 = 34'sh00FADBAFC;
         5'd3: atan_q30 = 34'sh007F56EA6;
         5'd4: atan_q30 = 34'sh003FEAB76;
         5'd5: atan_q30 = 34'sh001FFD55B;
         5'd6: atan_q30 = 34'sh000FFFAAA;
         5'd7: atan_q30 = 34'sh0007FFF55;
         5'd8: atan_q30 = 34'sh0003FFFEA;
         5'd9: atan_q30 = 34'sh0001FFFFD;
         5'd10: atan_q30 = 34'sh0000FFFFF;
         5'd11: atan_q30 = 34'sh00007FFFF;
         5'd12: atan_q30 = 34'sh00003FFFF;
         5'd13: atan_q30 = 34'sh00001FFFF;
         5'd14: atan_q30 = 34'sh00000FFFF;
         5'd15: atan_q30 = 34'sh000007FFF;
         5'd16: atan_q30 = 34'sh000003FFF;
         5'd17: atan_q30 = 34'sh000001FFF;
         5'd18: atan_q30 = 34'sh000000FFF;
         5'd19: atan_q30 = 34'sh0000007FF;
         5'd20: atan_q30 = 34'sh0000003FF;
         5'd21: atan_q30 = 34'sh0000001FF;
         5'd22: atan_q30 = 34'sh0000000FF;
         5'd23: atan_q30 = 34'sh00000007F;
         5'd24: atan_q30 = 34'sh00000003F;
         5'd25: atan_q30 = 34'sh00000001F;
         5'd26: atan_q30 = 34'sh00000000F;
         5'd27: atan_q30 = 34'sh000000008;
         5'd28: atan_q30 = 34'sh000000004;
         5'd29: atan_q30 = 34'sh000000002;
         5'd30: atan_q30 = 34'sh000000001;
         default: atan_q30 = '0;
      endcase
   endfunction

endpackage

@@ src/eer_cordic_cell.sv @@
// CORDIC cell: one rotation step for latitude and longitude lanes plus vector carry
`timescale 1ns / 1ps
module eer_cordic_cell
   import eer_pkg::*;
#(
   parameter int STEP = 0
) (
   input logic clock,
   input logic reset,
   input logic valid_in,
   input cordic_lane_type lat_in,
   input cordic_lane_type lon_in,
   input vec_item_type item_in,
   output logic valid_out,
   output cordic_lane_type lat_out,
   output cordic_lane_type lon_out,
   output vec_item_type item_out
);

   logic valid_ff;
   cordic_lane_type lat_ff, lat_in_w, lon_ff, lon_in_w;
   vec_item_type item_ff;

   function automatic cordic_lane_type rot(input cordic_lane_type a);
      cordic_lane_type r;
      logic signed [CsW-1:0] xs, ys;
      logic signed [AngW-1:0] at;
      xs = a.x >>> STEP;
      ys = a.y >>> STEP;
      at = atan_q30(5'(STEP));
      r = a;
      if (!a.z[AngW-1]) begin
         r.x = a.x - ys;
         r.y = a.y + xs;
         r.z = a.z - at;
      end else begin
         r.x = a.x + ys;
         r.y = a.y - xs;
         r.z = a.z + at;
      end
      return r;
   endfunction

   assign lat_in_w = rot(lat_in);
   assign lon_in_w = rot(lon_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      lat_ff <= lat_in_w;
      lon_ff <= lon_in_w;
      item_ff <= item_in;
   end

   assign valid_out = valid_ff;
   assign lat_out = lat_ff;
   assign lon_out = lon_ff;
   assign item_out = item_ff;

endmodule

@@ src/eer_rotate.sv @@
// Rotation back end: matrix entries, products, sums, rounding and saturation
`timescale 1ns / 1ps
module eer_rotate
   import eer_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic valid_in,
   input cordic_lane_type lat_in,
   input cordic_lane_type lon_in,
   input vec_item_type item_in,
   output logic valid_out,
   output logic signed [VecW-1:0] out_x,
   output logic signed [VecW-1:0] out_y,
   output logic signed [VecW-1:0] out_z
);

   localparam int PW = CsW + VecW;
   localparam int SW = PW + 3;
   localparam int HW = CsW + 21;

   logic [4:0] valid_ff;
   logic signed [CsW-1:0] sp_ff, cp_ff, sl_ff, cl_ff;
   vec_item_type it1_ff, it2_ff;
   logic signed [2*CsW-1:0] p_sc_ff, p_ss_ff, p_cc_ff, p_cs_ff;
   logic signed [CsW-1:0] sp2_ff, cp2_ff, sl2_ff, cl2_ff;
   logic signed [CsW-1:0] m_in [9];
   logic signed [VecW-1:0] vsel [3];
   logic signed [HW-1:0] phi_ff [9];
   logic signed [HW-1:0] plo_ff [9];
   logic signed [PW-1:0] prod_ff [9];
   logic signed [SW-1:0] sum_in [3];
   logic signed [VecW-1:0] res_ff [3];
   logic signed [SW-1:0] rnd [3];

   function automatic logic signed [CsW-1:0] qrnd(input logic signed [2*CsW-1:0] p);
      logic signed [2*CsW-1:0] t;
      t = p + (2*CsW)'(64'sd536870912);
      return CsW'(t >>> 30);
   endfunction

   always_comb begin
      logic signed [CsW-1:0] a, b, c, d, e, f, g, h, k;
      a = -sl2_ff; b = cl2_ff; c = '0;
      d = -qrnd(p_sc_ff); e = -qrnd(p_ss_ff); f = cp2_ff;
      g = qrnd(p_cc_ff); h = qrnd(p_cs_ff); k = sp2_ff;
      if (!it2_ff.func) begin
         m_in[0] = a; m_in[1] = b; m_in[2] = c;
         m_in[3] = d; m_in[4] = e; m_in[5] = f;
         m_in[6] = g; m_in[7] = h; m_in[8] = k;
      end else begin
         m_in[0] = a; m_in[1] = d; m_in[2] = g;
         m_in[3] = b; m_in[4] = e; m_in[5] = h;
         m_in[6] = c; m_in[7] = f; m_in[8] = k;
      end
      vsel[0] = it2_ff.vx;
      vsel[1] = it2_ff.vy;
      vsel[2] = it2_ff.vz;
      for (int r = 0; r < 3; r++) begin
         sum_in[r] = SW'(prod_ff[3*r]) + SW'(prod_ff[3*r+1]) + SW'(prod_ff[3*r+2]);
         rnd[r] = (sum_in[r] + SW'(64'sd536870912)) >>> 30;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[3:0], valid_in};
      end
      sp_ff <= lat_in.flip ? -lat_in.y : lat_in.y;
      cp_ff <= lat_in.flip ? -lat_in.x : lat_in.x;
      sl_ff <= lon_in.flip ? -lon_in.y : lon_in.y;
      cl_ff <= lon_in.flip ? -lon_in.x : lon_in.x;
      it1_ff <= item_in;
      p_sc_ff <= sp_ff * cl_ff;
      p_ss_ff <= sp_ff * sl_ff;
      p_cc_ff <= cp_ff * cl_ff;
      p_cs_ff <= cp_ff * sl_ff;
      sp2_ff <= sp_ff; cp2_ff <= cp_ff; sl2_ff <= sl_ff; cl2_ff <= cl_ff;
      it2_ff <= it1_ff;
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 3; k++) begin
            phi_ff[3*r+k] <= m_in[3*r+k] * $signed(vsel[k][VecW-1:20]);
            plo_ff[3*r+k] <= m_in[3*r+k] * $signed({1'b0, vsel[k][19:0]});
            prod_ff[3*r+k] <= (PW'(phi_ff[3*r+k]) <<< 20) + PW'(plo_ff[3*r+k]);
         end
         if (rnd[r] > SW'(VecMax)) res_ff[r] <= VecMax;
         else if (rnd[r] < SW'(VecMin)) res_ff[r] <= VecMin;
         else res_ff[r] <= VecW'(rnd[r]);
      end
   end

   assign valid_out = valid_ff[4];
   assign out_x = res_ff[0];
   assign out_y = res_ff[1];
   assign out_z = res_ff[2];

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) valid_in |-> ##5 valid_out)
      else $error("result lost in back end");
   assert property (@(posedge clock) disable iff (reset) !valid_in |-> ##5 !valid_out)
      else $error("result invented in back end");
   assert property (@(posedge clock) disable iff (reset)
      valid_out |-> (out_x <= VecMax && out_x >= VecMin))
      else $error("out_x out of range");
`endif

endmodule

@@ src/ecef_enu_rotation_unit.sv @@
// Top level of the ECEF/ENU rotation unit: angle folding, CORDIC cell chain, rotation
`timescale 1ns / 1ps
// Usage:
//   Command channel: a transaction is taken at each rising edge with start high and busy
//   low. busy is always low, so a new transaction may be issued every cycle.
//   req_func selects ECEF to ENU (0) or the transpose, ENU to ECEF (1).
//   req_latitude and req_longitude are Q2.29 radians; req_vec_* are 40-bit vectors.
//   Response channel: rsp_valid is high for exactly one cycle with rsp_out_x/y/z.
//   Path: start is registered, then passes the CORDIC cell chain and back end to rsp_valid.
//   Throughput: one transaction per cycle, set by the chain of CORDIC cells, one
//   per iteration, each rotating both angles in parallel, followed by five back-end
//   stages (sign fix, entry products, split vector products, product merge, sum and
//   saturation).
//   Reset clears all valid flags; transactions in flight are dropped.
//   The receiver cannot stall: every response is presented once and must be taken.
//   Results appear in the order transactions were taken.
module ecef_enu_rotation_unit
   import eer_pkg::*;
#(
   parameter int CORDIC_STEPS = CordicStepsDefault
) (
   input logic clock,
   input logic reset,
   input logic start,
   output logic busy,
   input logic req_func,
   input logic signed [31:0] req_latitude,
   input logic signed [31:0] req_longitude,
   input logic signed [VecW-1:0] req_vec_x,
   input logic signed [VecW-1:0] req_vec_y,
   input logic signed [VecW-1:0] req_vec_z,
   output logic rsp_valid,
   output logic signed [VecW-1:0] rsp_out_x,
   output logic signed [VecW-1:0] rsp_out_y,
   output logic signed [VecW-1:0] rsp_out_z
);

   localparam int N = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

   logic valid_ff;
   cordic_lane_type lat_ff, lon_ff, lat_in, lon_in;
   vec_item_type item_ff, item_in;
   logic v_c [N+1];
   cordic_lane_type lat_c [N+1];
   cordic_lane_type lon_c [N+1];
   vec_item_type it_c [N+1];

   function automatic cordic_lane_type fold(input logic signed [31:0] ang);
      cordic_lane_type r;
      logic signed [AngW-1:0] z;
      z = AngW'(ang) <<< 1;
      r.x = Gain;
      r.y = '0;
      r.flip = 1'b0;
      r.z = z;
      if (z > HalfPi) begin
         r.z = z - Pi; r.flip = 1'b1;
      end else if (z < -HalfPi) begin
         r.z = z + Pi; r.flip = 1'b1;
      end
      return r;
   endfunction

   assign busy = 1'b0;
   assign lat_in = fold(req_latitude);
   assign lon_in = fold(req_longitude);
   assign item_in = '{func: req_func, vx: req_vec_x, vy: req_vec_y, vz: req_vec_z};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= start && !busy;
      end
      lat_ff <= lat_in;
      lon_ff <= lon_in;
      item_ff <= item_in;
   end

   assign v_c[0] = valid_ff;
   assign lat_c[0] = lat_ff;
   assign lon_c[0] = lon_ff;
   assign it_c[0] = item_ff;

   for (genvar i = 0; i < N; i++) begin : g_cell
      eer_cordic_cell #(.STEP(i)) u_cell (
         .clock(clock), .reset(reset),
         .valid_in(v_c[i]), .lat_in(lat_c[i]), .lon_in(lon_c[i]), .item_in(it_c[i]),
         .valid_out(v_c[i+1]), .lat_out(lat_c[i+1]), .lon_out(lon_c[i+1]),
         .item_out(it_c[i+1])
      );
   end

   eer_rotate u_rotate (
      .clock(clock), .reset(reset),
      .valid_in(v_c[N]), .lat_in(lat_c[N]), .lon_in(lon_c[N]), .item_in(it_c[N]),
      .valid_out(rsp_valid), .out_x(rsp_out_x), .out_y(rsp_out_y), .out_z(rsp_out_z)
   );

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) start |=> v_c[0])
      else $error("transaction not launched");
   assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");
   assert property (@(posedge clock) disable iff (reset) v_c[0] |-> ##(N) v_c[N])
      else $error("transaction lost in cell chain");
`endif

endmodule
